/* hdl/cd_pkg.sv */
// ----------------------------------------------------------------------------
// cd_pkg
// Shared constants, codes and controller/datapath bundles for the
// Cholesky decomposition block.
// ----------------------------------------------------------------------------
package cd_pkg;

	localparam int MAX_N_DEF     = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W         = 32;
	localparam int IDX_W         = 6;
	localparam int SIZE_W        = 4;
	localparam int COL_W         = 4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	// source of the word written into the matrix store
	typedef enum logic [1:0] {
		WSEL_LOAD = 2'd0,
		WSEL_ROOT = 2'd1,
		WSEL_QUOT = 2'd2
	} wsel_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              mem_we;
		wsel_t             wsel;
		logic [IDX_W-1:0]  waddr;
		logic [IDX_W-1:0]  addr_a;
		logic [IDX_W-1:0]  addr_b;
		logic              acc_init;
		logic              mul_en;
		logic              acc_sub;
		logic              sqrt_start;
		logic              sqrt_step;
		logic              div_start;
		logic              div_step;
		logic              d_load;
		logic              out_load;
		logic              out_fail;
		logic [IDX_W-1:0]  out_index;
		logic              out_last;
		logic [COL_W-1:0]  fail_col;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic acc_nonpos;
	} stat_t;

endpackage

/* hdl/cd_in_if.sv */
// ----------------------------------------------------------------------------
// cd_in_if
// Input channel: one matrix element per word.
// ----------------------------------------------------------------------------
interface cd_in_if import cd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

/* hdl/cd_out_if.sv */
// ----------------------------------------------------------------------------
// cd_out_if
// Output channel: one result element or a failure word per word.
// ----------------------------------------------------------------------------
interface cd_out_if import cd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	logic [IDX_W-1:0]        element_index;
	logic                    status;
	logic [COL_W-1:0]        failed_column;
	logic                    last_result;

	modport source (output valid, output result_value, output element_index,
		output status, output failed_column, output last_result, input ready);
	modport sink (input valid, input result_value, input element_index,
		input status, input failed_column, input last_result, output ready);
endinterface

/* hdl/cholesky_decomposition.sv */
// Load: one word per cycle; the final word of the matrix starts decomposition.
// Decomposition: per element a read, a multiply-accumulate per earlier column,
// then a square root (32 steps) for a diagonal, else a divider (64 steps).
// Output: n*n words, each by store read, load and handshake, one at a time.
// A failed pivot gives one word. Reset is asynchronous: loading restarts at
// element 0, size register returns to 8; the store holds no reset value.
// ----------------------------------------------------------------------------
// cholesky_decomposition
// Top level: size register, controller and datapath around the two channels.
// ----------------------------------------------------------------------------
module cholesky_decomposition import cd_pkg::*; #(
	parameter int MAX_N     = MAX_N_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	cd_in_if.sink             in_chan,
	cd_out_if.source          out_chan
);

	logic [SIZE_W-1:0] matrix_size_q;
	cmd_t              cmd;
	stat_t             stat;

	// matrix size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	cd_controller #(.MAX_N(MAX_N)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.matrix_size (matrix_size_q),
		.in_valid    (in_chan.valid),
		.in_ready    (in_chan.ready),
		.out_valid   (out_chan.valid),
		.out_ready   (out_chan.ready),
		.out_last    (out_chan.last_result),
		.cmd         (cmd),
		.stat        (stat)
	);

	cd_datapath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_chan.element_value),
		.cmd        (cmd),
		.stat       (stat),
		.out_value  (out_chan.result_value),
		.out_index  (out_chan.element_index),
		.out_status (out_chan.status),
		.out_col    (out_chan.failed_column),
		.out_last   (out_chan.last_result)
	);

endmodule

/* hdl/cd_datapath.sv */
// ----------------------------------------------------------------------------
// cd_datapath
// Matrix store, multiplier, saturating accumulator, iterative square root,
// iterative divider and the output word register.
// ----------------------------------------------------------------------------
module cd_datapath import cd_pkg::*; #(
	parameter int MAX_N     = MAX_N_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] in_data,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output logic signed [VAL_W-1:0] out_value,
	output logic [IDX_W-1:0]        out_index,
	output logic                    out_status,
	output logic [COL_W-1:0]        out_col,
	output logic                    out_last
);

	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = $clog2(DEPTH);

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_a_q, rd_b_q;
	logic signed [63:0]      prod_q, acc_q;
	logic [63:0]             sq_v_q, sq_res_q, sq_bit_q;
	logic [63:0]             div_mag_q, div_quo_q;
	logic [31:0]             div_rem_q;
	logic                    div_neg_q;
	logic [31:0]             d_q;
	logic signed [VAL_W-1:0] wdata, root_sat, quot_sat;
	logic signed [64:0]      diff;
	logic signed [63:0]      sub_res;
	logic [63:0]             sq_try;
	logic [32:0]             rem_sh;
	logic [31:0]             quo_neg;

	// store write and registered dual read
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[cmd.waddr[AW-1:0]] <= wdata;
		end
		rd_a_q <= mem[cmd.addr_a[AW-1:0]];
		rd_b_q <= mem[cmd.addr_b[AW-1:0]];
	end

	// saturated root and quotient
	always_comb begin
		root_sat = sq_res_q[31] ? 32'sh7fff_ffff : $signed(sq_res_q[31:0]);
		quo_neg  = 32'd0 - div_quo_q[31:0];
		if (!div_neg_q) begin
			quot_sat = (div_quo_q > 64'h7fff_ffff) ? 32'sh7fff_ffff
				: $signed(div_quo_q[31:0]);
		end else begin
			quot_sat = (div_quo_q > 64'h8000_0000) ? 32'sh8000_0000
				: $signed(quo_neg);
		end
		unique case (cmd.wsel)
			WSEL_LOAD: wdata = in_data;
			WSEL_ROOT: wdata = root_sat;
			WSEL_QUOT: wdata = quot_sat;
			default:   wdata = in_data;
		endcase
	end

	// saturating subtract of the product, square-root trial and shifted remainder
	always_comb begin
		diff = {acc_q[63], acc_q} - {prod_q[63], prod_q};
		if (diff[64] != diff[63]) begin
			sub_res = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sub_res = diff[63:0];
		end
		sq_try = sq_res_q + sq_bit_q;
		rem_sh = {div_rem_q, div_mag_q[63]};
	end

	assign stat.acc_nonpos = acc_q[63] || (acc_q == 64'sd0);

	// multiply and accumulate
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= rd_a_q * rd_b_q;
		end
		if (cmd.acc_init) begin
			acc_q <= 64'({{(64-VAL_W){rd_a_q[VAL_W-1]}}, rd_a_q}) <<< FRAC_BITS;
		end else if (cmd.acc_sub) begin
			acc_q <= sub_res;
		end
	end

	// square root, one result bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q   <= acc_q;
			sq_res_q <= 64'd0;
			sq_bit_q <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= sq_try) begin
				sq_v_q   <= sq_v_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.d_load) begin
			d_q <= root_sat;
		end
	end

	// restoring divider on the magnitude, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_neg_q <= acc_q[63];
			div_mag_q <= acc_q[63] ? (64'd0 - acc_q) : acc_q;
			div_rem_q <= 32'd0;
			div_quo_q <= 64'd0;
		end else if (cmd.div_step) begin
			div_mag_q <= div_mag_q << 1;
			if (rem_sh >= {1'b0, d_q}) begin
				div_rem_q <= 32'(rem_sh - {1'b0, d_q});
				div_quo_q <= {div_quo_q[62:0], 1'b1};
			end else begin
				div_rem_q <= rem_sh[31:0];
				div_quo_q <= {div_quo_q[62:0], 1'b0};
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_status <= 1'b0;
			out_last   <= 1'b0;
		end else if (cmd.out_fail) begin
			out_status <= 1'b1;
			out_last   <= 1'b1;
		end else if (cmd.out_load) begin
			out_status <= 1'b0;
			out_last   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_fail) begin
			out_value <= '0;
			out_index <= '0;
			out_col   <= cmd.fail_col;
		end else if (cmd.out_load) begin
			out_value <= rd_a_q;
			out_index <= cmd.out_index;
			out_col   <= '0;
		end
	end

endmodule

/* hdl/cd_controller.sv */
// ----------------------------------------------------------------------------
// cd_controller
// Sequencer for load, column-by-column decomposition and result streaming.
// ----------------------------------------------------------------------------
module cd_controller import cd_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] matrix_size,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              out_last,
	output cmd_t              cmd,
	input  stat_t             stat
);

	localparam int CNT_W = $clog2(MAX_N + 1);
	localparam int CW    = $clog2(MAX_N * MAX_N + 1);
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 64;

	typedef enum logic [14:0] {
		ST_LOAD     = 15'b000000000000001,
		ST_INIT_RD  = 15'b000000000000010,
		ST_INIT     = 15'b000000000000100,
		ST_MAC_RD   = 15'b000000000001000,
		ST_MAC_MUL  = 15'b000000000010000,
		ST_MAC_ACC  = 15'b000000000100000,
		ST_EVAL     = 15'b000000001000000,
		ST_SQRT     = 15'b000000010000000,
		ST_WRITE_D  = 15'b000000100000000,
		ST_DIV      = 15'b000001000000000,
		ST_WRITE_L  = 15'b000010000000000,
		ST_OUT_RD   = 15'b000100000000000,
		ST_OUT_LD   = 15'b001000000000000,
		ST_OUT_WAIT = 15'b010000000000000,
		ST_FAIL     = 15'b100000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [5:0]       step_q, step_d;
	logic [CNT_W-1:0] n_eff;
	logic [CW-1:0]    total, widx, wnext;
	logic             diag;

	function automatic logic [IDX_W-1:0] addr_of(input logic [CNT_W-1:0] row,
		input logic [CNT_W-1:0] col, input logic [CNT_W-1:0] n);
		logic [2*CNT_W:0] a;
		a = (2*CNT_W+1)'(row * n) + (2*CNT_W+1)'(col);
		return IDX_W'(a);
	endfunction

	// effective size and element count
	always_comb begin
		if (matrix_size == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(matrix_size) > MAX_N) begin
			n_eff = CNT_W'(MAX_N);
		end else begin
			n_eff = CNT_W'(matrix_size);
		end
		total = CW'(n_eff * n_eff);
		widx  = (cnt_q >= total) ? '0 : cnt_q;
		wnext = widx + CW'(1);
		diag  = (i_q == j_q);
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT_WAIT) || (state_q == ST_FAIL);

	// next state and commands
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		cnt_d   = cnt_q;
		step_d  = step_q;
		cmd            = '0;
		cmd.wsel       = WSEL_LOAD;
		cmd.addr_a     = addr_of(i_q, k_q, n_eff);
		cmd.addr_b     = addr_of(j_q, k_q, n_eff);
		cmd.out_index  = IDX_W'(cnt_q);
		cmd.out_last   = (cnt_q == total - CW'(1));
		cmd.fail_col   = COL_W'(j_q) + COL_W'(1);
		unique case (state_q)
			ST_LOAD: begin
				cmd.waddr = IDX_W'(widx);
				if (in_valid) begin
					cmd.mem_we = 1'b1;
					if (wnext == total) begin
						cnt_d   = '0;
						i_d     = '0;
						j_d     = '0;
						state_d = ST_INIT_RD;
					end else begin
						cnt_d = wnext;
					end
				end
			end
			ST_INIT_RD: begin
				cmd.addr_a = addr_of(i_q, j_q, n_eff);
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				cmd.acc_init = 1'b1;
				k_d          = '0;
				state_d      = (j_q == '0) ? ST_EVAL : ST_MAC_RD;
			end
			ST_MAC_RD: begin
				state_d = ST_MAC_MUL;
			end
			ST_MAC_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_MAC_ACC;
			end
			ST_MAC_ACC: begin
				cmd.acc_sub = 1'b1;
				k_d         = k_q + CNT_W'(1);
				state_d     = (k_q + CNT_W'(1) == j_q) ? ST_EVAL : ST_MAC_RD;
			end
			ST_EVAL: begin
				step_d = '0;
				if (!diag) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (stat.acc_nonpos) begin
					state_d = ST_FAIL;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d        = ST_SQRT;
				end
				cmd.out_fail = diag && stat.acc_nonpos;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_d        = step_q + 6'd1;
				if (step_q == 6'(SQRT_STEPS - 1)) state_d = ST_WRITE_D;
			end
			ST_WRITE_D: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_ROOT;
				cmd.waddr  = addr_of(j_q, j_q, n_eff);
				cmd.d_load = 1'b1;
				i_d        = j_q + CNT_W'(1);
				cnt_d      = '0;
				state_d    = (j_q + CNT_W'(1) == n_eff) ? ST_OUT_RD : ST_INIT_RD;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 6'd1;
				if (step_q == 6'(DIV_STEPS - 1)) state_d = ST_WRITE_L;
			end
			ST_WRITE_L: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_QUOT;
				cmd.waddr  = addr_of(i_q, j_q, n_eff);
				cnt_d      = '0;
				if (i_q + CNT_W'(1) == n_eff) begin
					j_d     = j_q + CNT_W'(1);
					i_d     = j_q + CNT_W'(1);
					state_d = (j_q + CNT_W'(1) == n_eff) ? ST_OUT_RD : ST_INIT_RD;
				end else begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_INIT_RD;
				end
			end
			ST_OUT_RD: begin
				cmd.addr_a = IDX_W'(cnt_q);
				state_d    = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (out_ready) begin
					cnt_d = cnt_q + CW'(1);
					if (cnt_q == total - CW'(1)) begin
						cnt_d   = '0;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_OUT_RD;
					end
				end
			end
			ST_FAIL: begin
				if (out_ready) begin
					cnt_d   = '0;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
		end
	end

	// input and output never open together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output both open");

	// final word returns to loading
	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> (state_q == ST_LOAD))
		else $error("no return to load after final word");

	// root taken only of a positive residue
	a_sqrt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_start |-> !stat.acc_nonpos)
		else $error("square root of non-positive residue");

	// store written only while loading or on a result write
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> (state_q == ST_LOAD || state_q == ST_WRITE_D
			|| state_q == ST_WRITE_L))
		else $error("unexpected store write");

endmodule
